[hdl/bsd_pkg.sv]
// Shared types and constants for the BMP stream decoder.
package bsd_pkg;

    localparam int DIM_W = 13;
    localparam int ROWB_W = 15;

    localparam logic [31:0] HDR_LEN = 32'd54;
    localparam logic [31:0] HDR_LAST = 32'd53;
    localparam logic [15:0] BMP_SIG = 16'h4D42;
    localparam logic [15:0] BPP_24 = 16'd24;
    localparam logic [15:0] BPP_32 = 16'd32;
    localparam logic [31:0] MAX_WIDTH = 32'd4096;
    localparam logic [31:0] MAX_HEIGHT = 32'd4096;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [3:0] ST_OK = 4'd0;
    localparam logic [3:0] ST_SHORT = 4'd1;
    localparam logic [3:0] ST_SIGNATURE = 4'd2;
    localparam logic [3:0] ST_DEPTH = 4'd3;
    localparam logic [3:0] ST_COMPRESSED = 4'd4;
    localparam logic [3:0] ST_SIZE = 4'd5;
    localparam logic [3:0] ST_OFFSET_PAST_END = 4'd6;
    localparam logic [3:0] ST_TRUNCATED = 4'd7;
    localparam logic [3:0] ST_OFFSET_IN_HDR = 4'd8;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = 2;
    localparam int FIFO_CW = 3;

    typedef struct packed {
        logic        item_kind;
        logic [11:0] column;
        logic [11:0] dest_row;
        logic [31:0] argb_pixel;
        logic [3:0]  status_code;
        logic        last_result;
    } bsd_res_t;

    typedef struct packed {
        logic [1:0] count;
        bsd_res_t   first;
        bsd_res_t   second;
    } bsd_push_t;

endpackage

[hdl/bmp_stream_decoder_top.sv]
// Top level of the BMP stream decoder: input register, decode core, result queue.
//
//  channel | ports                  | carries
//  --------+------------------------+---------------------------------------------
//  input   | s_tvalid/tready/tdata  | file byte in tdata, end of file in tlast
//  result  | m_tvalid/tready/tdata  | pixel or status in tdata, kind in tuser,
//          |                        | last result of the file in tlast
//
// One byte per cycle sustained while the queue has room.
// Each byte passes the input register, then the combinational decode into a four-entry queue.
// Decode stalls only when the queue holds more than two results; s_tready then drops.
// aresetn is synchronous, active low; the first byte after reset starts a new file.
module bmp_stream_decoder_top
    import bsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] file_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [11:0] column, [23:12] dest_row, [55:24] argb_pixel,
                                   // [59:56] status_code, [63:60] zero
    output logic        m_tuser,   // [0] item_kind
    output logic        m_tlast
);

    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_eof_reg;
    logic       room;
    logic       fire;
    bsd_push_t  push;
    bsd_res_t   out_res;

    assign fire = in_vld_reg && room;
    assign s_tready = !in_vld_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_vld_reg <= 1'b1;
        end else if (fire) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_eof_reg <= s_tlast;
        end
    end

    bsd_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .file_byte   (in_byte_reg),
        .end_of_file (in_eof_reg),
        .push        (push)
    );

    bsd_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {4'b0000, out_res.status_code, out_res.argb_pixel,
                      out_res.dest_row, out_res.column};
    assign m_tuser = out_res.item_kind;
    assign m_tlast = out_res.last_result;

`ifndef ASSERT_OFF
    a_last_is_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser == KIND_STATUS) == m_tlast))
        else $error("last flag and status kind disagree");

    a_pixel_ok_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_PIXEL) |-> (m_tdata[59:56] == ST_OK))
        else $error("pixel beat carries a nonzero status");

    a_pixel_opaque: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_PIXEL) |-> (m_tdata[55:48] == ALPHA_OPAQUE))
        else $error("pixel beat is not opaque");

    a_no_push_without_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |-> (room && fire))
        else $error("results pushed without a decode cycle");
`endif

endmodule

[hdl/bsd_core.sv]
// Header capture, header check and pixel assembly per file byte; final status at end of file.
module bsd_core
    import bsd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  logic [7:0] file_byte,
    input  logic       end_of_file,
    output bsd_push_t  push
);

    logic [31:0]       pos_reg, pos_next;
    logic [15:0]       sig_reg, sig_next;
    logic [31:0]       wraw_reg, wraw_next;
    logic [31:0]       hraw_reg, hraw_next;
    logic [15:0]       bpp_reg, bpp_next;
    logic              comp_reg, comp_next;
    logic [31:0]       off_reg, off_next;
    logic [DIM_W-1:0]  width_reg, width_next;
    logic [DIM_W-1:0]  height_reg, height_next;
    logic              flip_reg, flip_next;
    logic              four_reg, four_next;
    logic [ROWB_W-1:0] data_bytes_reg, data_bytes_next;
    logic [ROWB_W-1:0] row_bytes_reg, row_bytes_next;
    logic [DIM_W-1:0]  col_reg, col_next;
    logic [DIM_W-1:0]  srow_reg, srow_next;
    logic [ROWB_W-1:0] bir_reg, bir_next;
    logic [1:0]        sub_reg, sub_next;
    logic [23:0]       pix_reg, pix_next;
    logic [3:0]        err_reg, err_next;

    logic [31:0]       habs;
    logic [3:0]        chk_code;
    logic              chk_four;
    logic [ROWB_W-1:0] chk_data_bytes;
    logic [ROWB_W-1:0] chk_row_bytes;
    logic [ROWB_W-1:0] bir_inc;
    logic [23:0]       pix_cur;
    logic [DIM_W-1:0]  row_calc;
    logic              pix_emit;
    logic              stat_emit;
    bsd_res_t          pix_res;
    bsd_res_t          stat_res;

    assign habs = hraw_reg[31] ? (~hraw_reg + 32'd1) : hraw_reg;
    assign chk_four = (bpp_reg == BPP_32);
    assign chk_data_bytes = chk_four ? {wraw_reg[DIM_W-1:0], 2'b00}
        : ({2'b00, wraw_reg[DIM_W-1:0]} + {1'b0, wraw_reg[DIM_W-1:0], 1'b0});
    assign chk_row_bytes = chk_four ? chk_data_bytes
        : ((chk_data_bytes + ROWB_W'(3)) & ~ROWB_W'(3));
    assign bir_inc = bir_reg + ROWB_W'(1);

    always_comb begin
        if (sig_reg != BMP_SIG) begin
            chk_code = ST_SIGNATURE;
        end else if (bpp_reg != BPP_24 && bpp_reg != BPP_32) begin
            chk_code = ST_DEPTH;
        end else if (comp_reg) begin
            chk_code = ST_COMPRESSED;
        end else if (wraw_reg == 32'd0 || wraw_reg[31] || wraw_reg > MAX_WIDTH ||
                     habs == 32'd0 || habs > MAX_HEIGHT) begin
            chk_code = ST_SIZE;
        end else if (off_reg < HDR_LEN) begin
            chk_code = ST_OFFSET_IN_HDR;
        end else begin
            chk_code = ST_OK;
        end
    end

    always_comb begin
        pix_cur = pix_reg;
        case (sub_reg)
            2'd0: pix_cur[7:0] = file_byte;
            2'd1: pix_cur[15:8] = file_byte;
            2'd2: pix_cur[23:16] = file_byte;
            default: pix_cur = pix_reg;
        endcase
    end

    assign row_calc = flip_reg ? (height_reg - DIM_W'(1) - srow_reg) : srow_reg;

    always_comb begin
        pos_next = pos_reg;
        sig_next = sig_reg;
        wraw_next = wraw_reg;
        hraw_next = hraw_reg;
        bpp_next = bpp_reg;
        comp_next = comp_reg;
        off_next = off_reg;
        width_next = width_reg;
        height_next = height_reg;
        flip_next = flip_reg;
        four_next = four_reg;
        data_bytes_next = data_bytes_reg;
        row_bytes_next = row_bytes_reg;
        col_next = col_reg;
        srow_next = srow_reg;
        bir_next = bir_reg;
        sub_next = sub_reg;
        pix_next = pix_reg;
        err_next = err_reg;
        pix_emit = 1'b0;
        stat_emit = 1'b0;
        pix_res = '0;
        stat_res = '0;

        if (fire) begin
            if (pos_reg < HDR_LEN) begin
                case (pos_reg[5:0])
                    6'd0:  sig_next[7:0] = file_byte;
                    6'd1:  sig_next[15:8] = file_byte;
                    6'd10: off_next[7:0] = file_byte;
                    6'd11: off_next[15:8] = file_byte;
                    6'd12: off_next[23:16] = file_byte;
                    6'd13: off_next[31:24] = file_byte;
                    6'd18: wraw_next[7:0] = file_byte;
                    6'd19: wraw_next[15:8] = file_byte;
                    6'd20: wraw_next[23:16] = file_byte;
                    6'd21: wraw_next[31:24] = file_byte;
                    6'd22: hraw_next[7:0] = file_byte;
                    6'd23: hraw_next[15:8] = file_byte;
                    6'd24: hraw_next[23:16] = file_byte;
                    6'd25: hraw_next[31:24] = file_byte;
                    6'd28: bpp_next[7:0] = file_byte;
                    6'd29: bpp_next[15:8] = file_byte;
                    6'd30, 6'd31, 6'd32, 6'd33: comp_next = comp_reg | (file_byte != 8'd0);
                    6'd53: begin
                        err_next = chk_code;
                        if (chk_code == ST_OK) begin
                            width_next = wraw_reg[DIM_W-1:0];
                            height_next = habs[DIM_W-1:0];
                            flip_next = ~hraw_reg[31];
                            four_next = chk_four;
                            data_bytes_next = chk_data_bytes;
                            row_bytes_next = chk_row_bytes;
                        end
                    end
                    default: ;
                endcase
            end else if (err_reg == ST_OK && pos_reg >= off_reg && srow_reg < height_reg) begin
                if (bir_reg < data_bytes_reg) begin
                    pix_next = pix_cur;
                    if (sub_reg == (four_reg ? 2'd3 : 2'd2)) begin
                        pix_emit = 1'b1;
                        pix_res.item_kind = KIND_PIXEL;
                        pix_res.column = col_reg[11:0];
                        pix_res.dest_row = row_calc[11:0];
                        pix_res.argb_pixel = {ALPHA_OPAQUE, pix_cur};
                        col_next = col_reg + DIM_W'(1);
                        sub_next = 2'd0;
                    end else begin
                        sub_next = sub_reg + 2'd1;
                    end
                end
                if (bir_inc == row_bytes_reg) begin
                    bir_next = '0;
                    col_next = '0;
                    sub_next = 2'd0;
                    srow_next = srow_reg + DIM_W'(1);
                end else begin
                    bir_next = bir_inc;
                end
            end

            if (pos_reg != 32'hFFFF_FFFF) begin
                pos_next = pos_reg + 32'd1;
            end

            if (end_of_file) begin
                stat_emit = 1'b1;
                stat_res.item_kind = KIND_STATUS;
                stat_res.last_result = 1'b1;
                if (err_next != ST_OK) begin
                    stat_res.status_code = err_next;
                end else if (pos_reg < HDR_LAST) begin
                    stat_res.status_code = ST_SHORT;
                end else if (pos_reg < off_next) begin
                    stat_res.status_code = ST_OFFSET_PAST_END;
                end else if (srow_next < height_next) begin
                    stat_res.status_code = ST_TRUNCATED;
                end else begin
                    stat_res.status_code = ST_OK;
                end
                pos_next = '0;
                sig_next = '0;
                wraw_next = '0;
                hraw_next = '0;
                bpp_next = '0;
                comp_next = 1'b0;
                off_next = '0;
                width_next = '0;
                height_next = '0;
                flip_next = 1'b0;
                four_next = 1'b0;
                data_bytes_next = '0;
                row_bytes_next = '0;
                col_next = '0;
                srow_next = '0;
                bir_next = '0;
                sub_next = 2'd0;
                pix_next = '0;
                err_next = ST_OK;
            end
        end
    end

    always_comb begin
        push = '0;
        if (pix_emit && stat_emit) begin
            push.count = 2'd2;
            push.first = pix_res;
            push.second = stat_res;
        end else if (pix_emit) begin
            push.count = 2'd1;
            push.first = pix_res;
        end else if (stat_emit) begin
            push.count = 2'd1;
            push.first = stat_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            sig_reg <= '0;
            wraw_reg <= '0;
            hraw_reg <= '0;
            bpp_reg <= '0;
            comp_reg <= 1'b0;
            off_reg <= '0;
            width_reg <= '0;
            height_reg <= '0;
            flip_reg <= 1'b0;
            four_reg <= 1'b0;
            data_bytes_reg <= '0;
            row_bytes_reg <= '0;
            col_reg <= '0;
            srow_reg <= '0;
            bir_reg <= '0;
            sub_reg <= 2'd0;
            pix_reg <= '0;
            err_reg <= ST_OK;
        end else begin
            pos_reg <= pos_next;
            sig_reg <= sig_next;
            wraw_reg <= wraw_next;
            hraw_reg <= hraw_next;
            bpp_reg <= bpp_next;
            comp_reg <= comp_next;
            off_reg <= off_next;
            width_reg <= width_next;
            height_reg <= height_next;
            flip_reg <= flip_next;
            four_reg <= four_next;
            data_bytes_reg <= data_bytes_next;
            row_bytes_reg <= row_bytes_next;
            col_reg <= col_next;
            srow_reg <= srow_next;
            bir_reg <= bir_next;
            sub_reg <= sub_next;
            pix_reg <= pix_next;
            err_reg <= err_next;
        end
    end

endmodule

[hdl/bsd_out_fifo.sv]
// Result queue taking up to two results per cycle and handing out one per beat.
module bsd_out_fifo
    import bsd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  bsd_push_t push,
    output logic      room,
    output logic      out_valid,
    input  logic      out_ready,
    output bsd_res_t  out_res
);

    bsd_res_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg;
    logic [FIFO_AW-1:0]   wr_ptr_b;
    logic                 pop;

    assign out_valid = (count_reg != '0);
    assign out_res = mem_reg[rd_ptr_reg];
    assign pop = out_valid && out_ready;
    assign room = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign wr_ptr_b = wr_ptr_reg + FIFO_AW'(1);

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_b] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(push.count);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_reg + FIFO_CW'(push.count) - FIFO_CW'(pop);
        end
    end

endmodule
